// ===== rtl/stbs_pkg.sv =====
// Shared widths, command codes and defaults for the sorted table search block.
package stbs_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int IDX_W  = 10;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 11;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]  cnt_t;

endpackage

// ===== rtl/stbs_ram.sv =====
// Generic simple dual port RAM with registered read data.
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/sorted_table_binary_search_top.sv =====
// A write is stored at the accepting edge and gives no result; busy stays low.
// A search runs each probe as a table read, then a compare; the result strobe is
// registered from the last compare. An empty table answers in the cycle after the
// start and leaves busy low; otherwise busy is high for the whole search.
// Reset (rst_n low, synchronous) clears the sequencer, the strobe and used_entries;
// table contents stay undefined until written. The receiver cannot stall results.
module sorted_table_binary_search_top #(
  parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_WIDTH = stbs_pkg::DEF_VALUE_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_command,
  input  stbs_pkg::idx_t       in_entry_index,
  input  logic signed [stbs_pkg::DATA_W-1:0] in_data_value,
  input  logic                 cfg_wr_en,
  input  stbs_pkg::cnt_t       cfg_used_entries,
  output logic                 out_valid,
  output logic                 out_found,
  output stbs_pkg::idx_t       out_match_index
);
  import stbs_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;

  logic [1:0]             state_r, state_nxt;
  cnt_t                   used_r;
  logic [CW-1:0]          lo_r, lo_nxt;
  logic [CW-1:0]          end_r, end_nxt;
  logic [CW-1:0]          mid_r;
  logic [VALUE_WIDTH-1:0] target_r, target_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_found_r, out_found_nxt;
  idx_t                   out_idx_r, out_idx_nxt;

  logic                   accept_w;
  logic [VALUE_WIDTH-1:0] in_val_w;
  logic [31:0]            idx_ext_w;
  logic [31:0]            used_ext_w;
  logic [31:0]            n_ext_w;
  logic [31:0]            mid_ext_w;
  logic [CW:0]            sum_w;
  logic [CW-1:0]          mid_w;
  logic [CW-1:0]          mid_inc_w;
  logic                   wr_en_w;
  logic [VALUE_WIDTH-1:0] rd_data_w;
  logic                   is_eq_w;
  logic                   is_lt_w;

  assign accept_w = start && !busy;
  assign busy     = (state_r != ST_IDLE);

  // Narrow or widen the incoming word to the table width.
  generate
    if (VALUE_WIDTH <= DATA_W) begin : g_val_narrow
      assign in_val_w = in_data_value[VALUE_WIDTH-1:0];
    end else begin : g_val_wide
      assign in_val_w = {{(VALUE_WIDTH-DATA_W){1'b0}}, in_data_value};
    end
  endgenerate

  assign idx_ext_w  = 32'(in_entry_index);
  assign used_ext_w = 32'(used_r);
  assign n_ext_w    = (used_ext_w > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : used_ext_w;
  assign wr_en_w    = accept_w && (in_command == CMD_WRITE) &&
                      (idx_ext_w < 32'(TABLE_DEPTH));

  // Probe point: floor((lo + end - 1) / 2), with lo < end while probing.
  assign sum_w     = {1'b0, lo_r} + {1'b0, end_r} - {{CW{1'b0}}, 1'b1};
  assign mid_w     = sum_w[CW:1];
  assign mid_inc_w = mid_r + {{(CW-1){1'b0}}, 1'b1};
  assign mid_ext_w = 32'(mid_r);

  assign is_eq_w = (rd_data_w == target_r);
  assign is_lt_w = ($signed(target_r) < $signed(rd_data_w));

  stbs_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en_w),
    .wr_addr (idx_ext_w[AW-1:0]),
    .wr_data (in_val_w),
    .rd_en   (state_r == ST_PROBE),
    .rd_addr (mid_w[AW-1:0]),
    .rd_data (rd_data_w)
  );

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    end_nxt       = end_r;
    target_nxt    = target_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept_w && (in_command == CMD_SEARCH)) begin
          target_nxt = in_val_w;
          lo_nxt     = '0;
          end_nxt    = n_ext_w[CW-1:0];
          if (n_ext_w == 32'd0) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b0;
            out_idx_nxt   = '0;
          end else begin
            state_nxt = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (is_eq_w) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_idx_nxt   = mid_ext_w[IDX_W-1:0];
          state_nxt     = ST_IDLE;
        end else begin
          if (is_lt_w) begin
            end_nxt = mid_r;
          end else begin
            lo_nxt = mid_inc_w;
          end
          // Range empty: report a miss.
          if ((is_lt_w ? lo_r : mid_inc_w) >= (is_lt_w ? mid_r : end_r)) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b0;
            out_idx_nxt   = '0;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_PROBE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        used_r <= cfg_used_entries;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    end_r       <= end_nxt;
    target_r    <= target_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
    if (state_r == ST_PROBE) begin
      mid_r <= mid_w;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_index = out_idx_r;

  // A result only follows a compare or a search started on an empty table.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_CMP) ||
                  ($past(accept_w) && ($past(in_command) == CMD_SEARCH)))
    else $error("result strobe without a search");

  a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_match_index == '0))
    else $error("miss reported with nonzero index");

  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> (lo_r < end_r) && (end_r <= CW'(TABLE_DEPTH)))
    else $error("probe with empty or oversized range");

  a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept_w && (in_command == CMD_WRITE)) |=> !busy && !out_valid)
    else $error("write item started a search");

endmodule
